[design/sfq_pkg.sv]
package sfq_pkg;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_SEARCH = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast operation for the row of storage cells
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_POP    = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    localparam int unsigned FIELD_W    = 32;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned OCC_W      = 5;

endpackage

[design/sfq_cell.sv]
module sfq_cell #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sfq_pkg::cell_op_t     op,
    input  logic                  prev_valid,
    input  logic                  next_valid,
    input  logic [DATA_WIDTH-1:0] next_data,
    input  logic [DATA_WIDTH-1:0] head_data,
    input  logic [DATA_WIDTH-1:0] in_data,
    output logic                  valid,
    output logic [DATA_WIDTH-1:0] data
);
    import sfq_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (op)
            OP_HOLD: begin
            end
            OP_PUSH: begin
                // first free cell behind the last occupied one takes the value
                if (!valid_reg && prev_valid) begin
                    valid_next = 1'b1;
                    data_next  = in_data;
                end
            end
            OP_POP: begin
                if (valid_reg) begin
                    if (next_valid) begin
                        data_next = next_data;
                    end else begin
                        valid_next = 1'b0;
                    end
                end
            end
            OP_ROTATE: begin
                // last occupied cell wraps the head value around
                if (valid_reg) begin
                    data_next = next_valid ? next_data : head_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

[design/searchable_fifo_queue_core.sv]
// Searchable FIFO queue.
// Input channel (s_valid/s_ready) carries a command and a value: enqueue,
// dequeue, peek at head, or search for the first entry equal to the value.
// Each accepted transaction yields exactly one result on the m_ channel with
// status, item value, found flag, position from head, occupancy and empty flag.
// Entries live in a row of DEPTH cells ordered from head (cell 0) to tail.
// Enqueue fills the first free cell, dequeue shifts every cell one step
// toward the head.
// Enqueue, dequeue, peek and any command on an empty queue register their
// result in the cycle after acceptance. A search rotates the row one cell
// per cycle, comparing at the head cell, then registers its result once free;
// the rotation count equals the occupancy, which restores the original order.
// One command is in flight at a time; s_ready is high when no search runs and
// the result register is empty or being taken in the same cycle.
// When the receiver stalls, the result holds on the m_ ports and no new
// transaction is accepted until it is taken.
// Reset (aresetn low, synchronous) empties the queue and the result register.
module searchable_fifo_queue_core #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_item_value,
    output logic               m_found,
    output logic [3:0]         m_position,
    output logic [4:0]         m_occupancy,
    output logic               m_is_empty
);
    import sfq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned EXT_W = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  found_reg, found_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_status_reg, m_status_next;
    logic [FIELD_W-1:0]    m_item_reg, m_item_next;
    logic                  m_found_reg, m_found_next;
    logic [POS_W-1:0]      m_pos_reg, m_pos_next;
    logic [OCC_W-1:0]      m_occ_reg, m_occ_next;
    logic                  m_empty_reg, m_empty_next;

    cell_op_t              cell_op;
    logic [DEPTH-1:0]      cell_valid;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    logic signed [EXT_W-1:0] val_ext;
    logic [DATA_WIDTH-1:0]   key_in;
    logic signed [EXT_W-1:0] head_ext;
    logic [FIELD_W-1:0]      head_item;
    logic                    out_free;
    logic                    accept;
    logic                    is_full;
    logic                    is_empty_now;

    assign val_ext   = EXT_W'(s_value);
    assign key_in    = val_ext[DATA_WIDTH-1:0];
    assign head_ext  = EXT_W'(signed'(cell_data[0]));
    assign head_item = head_ext[FIELD_W-1:0];

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == S_IDLE) && out_free;
    assign accept       = s_valid && s_ready;
    assign is_full      = (count_reg == CNT_W'(DEPTH));
    assign is_empty_now = (count_reg == '0);

    // Low bits of the occupancy and position, zero-extended when narrow
    function automatic logic [OCC_W-1:0] occ_field(input logic [CNT_W-1:0] c);
        logic [FIELD_W-1:0] w;
        w = FIELD_W'(c);
        return w[OCC_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pos_field(input logic [CNT_W-1:0] p);
        logic [FIELD_W-1:0] w;
        w = FIELD_W'(p);
        return w[POS_W-1:0];
    endfunction

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        key_next      = key_reg;
        cell_op       = OP_HOLD;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_item_next   = m_item_reg;
        m_found_next  = m_found_reg;
        m_pos_next    = m_pos_reg;
        m_occ_next    = m_occ_reg;
        m_empty_next  = m_empty_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_item_next   = '0;
                    m_found_next  = 1'b0;
                    m_pos_next    = '0;
                    unique case (command_t'(s_command))
                        CMD_ENQ: begin
                            if (is_full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                cell_op    = OP_PUSH;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEQ: begin
                            if (is_empty_now) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                cell_op     = OP_POP;
                                m_item_next = head_item;
                                count_next  = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_PEEK: begin
                            if (is_empty_now) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                m_item_next = head_item;
                            end
                        end
                        CMD_SEARCH: begin
                            if (is_empty_now) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                // result comes after the rotation pass
                                m_valid_next = 1'b0;
                                key_next     = key_in;
                                idx_next     = '0;
                                pos_next     = '0;
                                found_next   = 1'b0;
                                state_next   = S_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                    m_occ_next   = occ_field(count_next);
                    m_empty_next = (count_next == '0);
                end
            end
            S_SEARCH: begin
                cell_op = OP_ROTATE;
                if (!found_reg && (cell_data[0] == key_reg)) begin
                    found_next = 1'b1;
                    pos_next   = idx_reg;
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == count_reg - CNT_W'(1)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_item_next   = '0;
                    m_found_next  = found_reg;
                    m_pos_next    = pos_field(pos_reg);
                    m_occ_next    = occ_field(count_reg);
                    m_empty_next  = is_empty_now;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        key_reg      <= key_next;
        m_status_reg <= m_status_next;
        m_item_reg   <= m_item_next;
        m_found_reg  <= m_found_next;
        m_pos_reg    <= m_pos_next;
        m_occ_reg    <= m_occ_next;
        m_empty_reg  <= m_empty_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                  prev_v;
            logic                  next_v;
            logic [DATA_WIDTH-1:0] next_d;

            if (gi == 0) begin : g_first
                assign prev_v = 1'b1;
            end else begin : g_mid
                assign prev_v = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign next_v = 1'b0;
                assign next_d = '0;
            end else begin : g_body
                assign next_v = cell_valid[gi+1];
                assign next_d = cell_data[gi+1];
            end

            sfq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .op         (cell_op),
                .prev_valid (prev_v),
                .next_valid (next_v),
                .next_data  (next_d),
                .head_data  (cell_data[0]),
                .in_data    (key_in),
                .valid      (cell_valid[gi]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_item_value = m_item_reg;
    assign m_found      = m_found_reg;
    assign m_position   = m_pos_reg;
    assign m_occupancy  = m_occ_reg;
    assign m_is_empty   = m_empty_reg;

endmodule

[test/searchable_fifo_queue_core_test.sv]
module searchable_fifo_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 500;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = QUEUE_DEPTH + 8;
    localparam int HOLD_OFF_AT   = 120;
    localparam int HOLD_OFF_LEN  = 400;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] item_value;
        logic               found;
        logic [3:0]         position;
        logic [4:0]         occupancy;
        logic               is_empty;
    } queue_result_t;

    // Shadow copy of the queue plus the results still owed by the block.
    class sfq_scoreboard;
        logic signed [31:0] held_values [QUEUE_DEPTH];
        int                 head_slot;
        int                 tail_slot;
        int                 held;
        queue_result_t      owed_results [$];
        int                 failures;

        function new();
            head_slot = 0;
            tail_slot = 0;
            held      = 0;
            failures  = 0;
        endfunction

        function int held_count();
            return held;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function logic signed [31:0] entry_at(int distance);
            return held_values[(head_slot + distance) % QUEUE_DEPTH];
        endfunction

        function void note_command(command_t cmd, logic signed [31:0] val);
            queue_result_t r;
            bit            hit;
            r.status     = ST_OK;
            r.item_value = '0;
            r.found      = 1'b0;
            r.position   = '0;
            hit          = 1'b0;
            case (cmd)
                CMD_ENQ: begin
                    if (held >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        held_values[tail_slot] = val;
                        tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
                        held++;
                    end
                end
                CMD_DEQ: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.item_value = held_values[head_slot];
                        head_slot = (head_slot + 1) % QUEUE_DEPTH;
                        held--;
                    end
                end
                CMD_PEEK: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else r.item_value = held_values[head_slot];
                end
                default: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        for (int i = 0; i < held; i++) begin
                            if (!hit && entry_at(i) == val) begin
                                hit        = 1'b1;
                                r.found    = 1'b1;
                                r.position = i[3:0];
                            end
                        end
                    end
                end
            endcase
            r.occupancy = held[4:0];
            r.is_empty  = (held == 0);
            owed_results.push_back(r);
        endfunction

        function void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (owed_results.size() == 0) begin
                failures++;
                if (failures <= 10) $display("result transaction with no command outstanding");
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", 32'(want.status), 32'(got.status));
            if (got.item_value !== want.item_value)
                flag_mismatch("item_value", want.item_value, got.item_value);
            if (got.found !== want.found)
                flag_mismatch("found", 32'(want.found), 32'(got.found));
            if (got.position !== want.position)
                flag_mismatch("position", 32'(want.position), 32'(got.position));
            if (got.occupancy !== want.occupancy)
                flag_mismatch("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            if (got.is_empty !== want.is_empty)
                flag_mismatch("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = CMD_ENQ;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic signed [31:0] m_item_value;
    logic               m_found;
    logic [3:0]         m_position;
    logic [4:0]         m_occupancy;
    logic               m_is_empty;

    int                 cycle_count = 0;
    sfq_scoreboard      board;

    logic signed [31:0] fill_values [QUEUE_DEPTH] = '{
        32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
        32'sh5555_5555, 32'shaaaa_aaaa, 32'sd7, 32'sd7,
        32'sd100, 32'sd101, 32'sd102, 32'sd103,
        32'sd104, 32'sd105, 32'sd106, 32'sd107
    };

    searchable_fifo_queue_core #(
        .DEPTH      (QUEUE_DEPTH),
        .DATA_WIDTH (32)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_item_value (m_item_value),
        .m_found      (m_found),
        .m_position   (m_position),
        .m_occupancy  (m_occupancy),
        .m_is_empty   (m_is_empty)
    );

    always #5 aclk = ~aclk;

    // Mostly back-to-back, some short gaps, now and then a long one.
    function automatic int idle_cycles(bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Extremes and a small pool for duplicate entries, else anything.
    function automatic logic signed [31:0] pick_value();
        int roll;
        int pick;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) return 32'sh8000_0000;
            if (pick == 1) return 32'sh7fff_ffff;
            if (pick == 2) return 32'sh0000_0000;
            return 32'shffff_ffff;
        end
        if (roll <= 3) return $urandom_range(0, 7);
        return $urandom;
    endfunction

    task automatic send_command(command_t cmd, logic signed [31:0] val, bit gaps_on);
        int gap;
        gap = idle_cycles(gaps_on);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= val;
        do @(posedge aclk); while (!s_ready);
        board.note_command(cmd, val);
    endtask

    // Cycle watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, quiet stretches, and one long hold-off so the
    // block backs up and drops s_ready while commands keep coming.
    initial begin
        int            stall_left;
        int            seen;
        bit            held_off;
        bit            stalls_on;
        queue_result_t got;
        stall_left = 0;
        seen       = 0;
        held_off   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.status     = m_status;
                got.item_value = m_item_value;
                got.found      = m_found;
                got.position   = m_position;
                got.occupancy  = m_occupancy;
                got.is_empty   = m_is_empty;
                board.check_result(got);
                seen++;
            end
            stalls_on = ((cycle_count / 256) % 4) != 0;
            if (!held_off && seen >= HOLD_OFF_AT) begin
                held_off   = 1'b1;
                stall_left = HOLD_OFF_LEN;
            end else if (stall_left == 0 && stalls_on && $urandom_range(0, 99) < 25) begin
                stall_left = idle_cycles(1'b1);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int                 roll;
        int                 enq_w;
        int                 deq_w;
        int                 peek_w;
        command_t           cmd;
        logic signed [31:0] val;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-queue cases, fill with extremes, full, search corners
        send_command(CMD_DEQ, 32'sh1234_5678, 1'b1);
        send_command(CMD_PEEK, 32'shffff_ffff, 1'b1);
        send_command(CMD_SEARCH, 32'sh0, 1'b1);
        for (int i = 0; i < QUEUE_DEPTH; i++) send_command(CMD_ENQ, fill_values[i], 1'b1);
        send_command(CMD_ENQ, 32'sd42, 1'b1);
        send_command(CMD_SEARCH, 32'sd107, 1'b1);
        send_command(CMD_SEARCH, 32'sd7, 1'b1);
        send_command(CMD_SEARCH, 32'sd12345, 1'b1);
        send_command(CMD_PEEK, 32'sh0, 1'b1);
        send_command(CMD_DEQ, 32'sh0, 1'b1);
        send_command(CMD_SEARCH, 32'sh7fff_ffff, 1'b1);

        // Random: alternate fill-heavy, drain-heavy and mixed stretches so the
        // queue swings between empty and full.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 60) % 3)
                0:       begin enq_w = 55; deq_w = 15; peek_w = 10; end
                1:       begin enq_w = 15; deq_w = 50; peek_w = 15; end
                default: begin enq_w = 30; deq_w = 25; peek_w = 15; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < enq_w) cmd = CMD_ENQ;
            else if (roll < enq_w + deq_w) cmd = CMD_DEQ;
            else if (roll < enq_w + deq_w + peek_w) cmd = CMD_PEEK;
            else cmd = CMD_SEARCH;
            if (cmd == CMD_SEARCH && board.held_count() > 0 && $urandom_range(0, 1))
                val = board.entry_at($urandom_range(0, board.held_count() - 1));
            else if (cmd == CMD_ENQ || cmd == CMD_SEARCH)
                val = pick_value();
            else
                val = $urandom;
            send_command(cmd, val, ((n / 32) % 4) != 0);
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
